>>> rtl/bhq_pkg.sv
// Shared types and constants for the binary min-heap queue.
// No dependencies.
package bhq_pkg;

  typedef logic signed [31:0] key_t;

  localparam int KEY_W    = 32;
  localparam int REQ_W    = 2;
  localparam int POS_W    = 6;
  localparam int STATUS_W = 3;
  localparam int COUNT_W  = 7;

  localparam logic [REQ_W-1:0] REQ_INSERT   = 2'd0;
  localparam logic [REQ_W-1:0] REQ_EXTRACT  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_DECREASE = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_GREATER = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FULL    = 3'd3;
  localparam logic [STATUS_W-1:0] ST_BADPOS  = 3'd4;

  localparam key_t INT_MAX = 32'sh7FFF_FFFF;

endpackage

>>> rtl/bhq_cmp.sv
// Shared signed key comparator used by every sift step.
// Depends on bhq_pkg.
module bhq_cmp (
  input  bhq_pkg::key_t a,
  input  bhq_pkg::key_t b,
  output logic          lt
);

  assign lt = (a < b);

endmodule

>>> rtl/binary_min_heap_queue.sv
// Binary min-heap priority queue of signed 32-bit keys: top level, sequencer and key store.
// Depends on bhq_pkg and bhq_cmp.
//
// Each request (insert, extract-minimum, decrease-key) is taken only while the sequencer is
// idle and gives one result carrying the extracted key, a status, the entry count and the
// current minimum. Keys sit in a single-port-write, registered-read array; one comparator is
// shared by all steps. Insert and decrease-key climb one level per parent read (S_UP_RD) and
// parent compare (S_UP_CMP); extract descends one level per left-child read (S_DN_RDL), left
// compare (S_DN_CMPL) and, where a right child exists, right compare (S_DN_CMPR); a decrease
// with a larger key is rejected after its compare (S_DEC_CMP); other error cases and the
// unused request code go straight to S_FIN. Each compare uses a registered key-store read.
// A finished result waits in an output register, and the next request may be taken meanwhile.
module binary_min_heap_queue #(
  parameter int CAPACITY = 64
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [bhq_pkg::REQ_W-1:0]        in_req_type,
  input  bhq_pkg::key_t                    in_new_key,
  input  logic [bhq_pkg::POS_W-1:0]        in_position,
  output logic                             out_valid,
  input  logic                             out_ready,
  output bhq_pkg::key_t                    out_key_out,
  output logic [bhq_pkg::STATUS_W-1:0]     out_status,
  output logic [bhq_pkg::COUNT_W-1:0]      out_entry_count,
  output bhq_pkg::key_t                    out_min_key
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int XW = AW + 2;

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_DEC_CMP = 4'd1;
  localparam logic [3:0] S_UP_RD   = 4'd2;
  localparam logic [3:0] S_UP_CMP  = 4'd3;
  localparam logic [3:0] S_DN_LD   = 4'd4;
  localparam logic [3:0] S_DN_RDL  = 4'd5;
  localparam logic [3:0] S_DN_CMPL = 4'd6;
  localparam logic [3:0] S_DN_CMPR = 4'd7;
  localparam logic [3:0] S_FIN     = 4'd8;

  logic [3:0]                     state_r, state_nxt;
  logic [AW-1:0]                  idx_r, idx_nxt;
  logic [CW-1:0]                  cnt_r, cnt_nxt;
  bhq_pkg::key_t                  key_r, key_nxt;
  bhq_pkg::key_t                  kout_r, kout_nxt;
  logic [bhq_pkg::STATUS_W-1:0]   status_r, status_nxt;
  bhq_pkg::key_t                  minv_r, minv_nxt;
  logic                           left_r, left_nxt;
  bhq_pkg::key_t                  root_r;

  logic                           out_valid_r;
  bhq_pkg::key_t                  out_key_r, out_min_r;
  logic [bhq_pkg::STATUS_W-1:0]   out_status_r;
  logic [bhq_pkg::COUNT_W-1:0]    out_count_r;

  bhq_pkg::key_t                  mem [CAPACITY];
  bhq_pkg::key_t                  rd_data_r;
  logic [AW-1:0]                  rd_addr;
  logic                           mem_we;
  logic [AW-1:0]                  wr_addr;
  bhq_pkg::key_t                  wr_data;

  bhq_pkg::key_t                  cmp_a, cmp_b;
  logic                           cmp_lt;

  logic                           in_fire;
  logic                           out_free;
  logic [AW-1:0]                  par_idx;
  logic [XW-1:0]                  l_idx, r_idx, cnt_x;

  bhq_cmp u_cmp (
    .a  (cmp_a),
    .b  (cmp_b),
    .lt (cmp_lt)
  );

  assign in_ready = (state_r == S_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;
  assign par_idx  = (idx_r - AW'(1)) >> 1;
  assign l_idx    = {1'b0, idx_r, 1'b1};
  assign r_idx    = l_idx + XW'(1);
  assign cnt_x    = XW'(cnt_r);

  always_comb begin
    case (state_r)
      S_UP_CMP:  begin cmp_a = key_r;     cmp_b = rd_data_r; end
      S_DN_CMPR: begin cmp_a = rd_data_r; cmp_b = minv_r;    end
      default:   begin cmp_a = rd_data_r; cmp_b = key_r;     end
    endcase
  end

  always_comb begin
    state_nxt  = state_r;
    idx_nxt    = idx_r;
    cnt_nxt    = cnt_r;
    key_nxt    = key_r;
    kout_nxt   = kout_r;
    status_nxt = status_r;
    minv_nxt   = minv_r;
    left_nxt   = left_r;
    rd_addr    = idx_r;
    mem_we     = 1'b0;
    wr_addr    = idx_r;
    wr_data    = key_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          kout_nxt   = '0;
          status_nxt = bhq_pkg::ST_OK;
          key_nxt    = in_new_key;
          state_nxt  = S_FIN;
          case (in_req_type)
            bhq_pkg::REQ_INSERT: begin
              if (cnt_r >= CW'(CAPACITY)) begin
                status_nxt = bhq_pkg::ST_FULL;
              end else begin
                idx_nxt   = AW'(cnt_r);
                cnt_nxt   = cnt_r + CW'(1);
                state_nxt = S_UP_RD;
              end
            end
            bhq_pkg::REQ_EXTRACT: begin
              if (cnt_r == '0) begin
                status_nxt = bhq_pkg::ST_EMPTY;
                kout_nxt   = bhq_pkg::INT_MAX;
              end else begin
                kout_nxt = root_r;
                cnt_nxt  = cnt_r - CW'(1);
                idx_nxt  = '0;
                rd_addr  = AW'(cnt_r - CW'(1));
                if (cnt_r != CW'(1)) begin
                  state_nxt = S_DN_LD;
                end
              end
            end
            bhq_pkg::REQ_DECREASE: begin
              if (32'(in_position) >= 32'(cnt_r)) begin
                status_nxt = bhq_pkg::ST_BADPOS;
              end else begin
                idx_nxt   = AW'(in_position);
                rd_addr   = AW'(in_position);
                state_nxt = S_DEC_CMP;
              end
            end
            default: begin
              state_nxt = S_FIN;
            end
          endcase
        end
      end
      S_DEC_CMP: begin
        if (cmp_lt) begin
          status_nxt = bhq_pkg::ST_GREATER;
          state_nxt  = S_FIN;
        end else begin
          state_nxt = S_UP_RD;
        end
      end
      S_UP_RD: begin
        if (idx_r == '0) begin
          mem_we    = 1'b1;
          state_nxt = S_FIN;
        end else begin
          rd_addr   = par_idx;
          state_nxt = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        mem_we = 1'b1;
        if (cmp_lt) begin
          wr_data   = rd_data_r;
          idx_nxt   = par_idx;
          state_nxt = S_UP_RD;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_DN_LD: begin
        key_nxt   = rd_data_r;
        state_nxt = S_DN_RDL;
      end
      S_DN_RDL: begin
        if (l_idx >= cnt_x) begin
          mem_we    = 1'b1;
          state_nxt = S_FIN;
        end else begin
          rd_addr   = AW'(l_idx);
          state_nxt = S_DN_CMPL;
        end
      end
      S_DN_CMPL: begin
        left_nxt = cmp_lt;
        minv_nxt = cmp_lt ? rd_data_r : key_r;
        if (r_idx < cnt_x) begin
          rd_addr   = AW'(r_idx);
          state_nxt = S_DN_CMPR;
        end else begin
          mem_we = 1'b1;
          if (cmp_lt) begin
            wr_data   = rd_data_r;
            idx_nxt   = AW'(l_idx);
            state_nxt = S_DN_RDL;
          end else begin
            state_nxt = S_FIN;
          end
        end
      end
      S_DN_CMPR: begin
        mem_we = 1'b1;
        if (cmp_lt) begin
          wr_data   = rd_data_r;
          idx_nxt   = AW'(r_idx);
          state_nxt = S_DN_RDL;
        end else if (left_r) begin
          wr_data   = minv_r;
          idx_nxt   = AW'(l_idx);
          state_nxt = S_DN_RDL;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      if (state_r == S_FIN && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx_r    <= idx_nxt;
    key_r    <= key_nxt;
    kout_r   <= kout_nxt;
    status_r <= status_nxt;
    minv_r   <= minv_nxt;
    left_r   <= left_nxt;
    if (mem_we && wr_addr == '0) begin
      root_r <= wr_data;
    end
    if (state_r == S_FIN && out_free) begin
      out_key_r    <= kout_r;
      out_status_r <= status_r;
      out_count_r  <= bhq_pkg::COUNT_W'(cnt_r);
      out_min_r    <= (cnt_r == '0) ? bhq_pkg::INT_MAX : root_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_key_out     = out_key_r;
  assign out_status      = out_status_r;
  assign out_entry_count = out_count_r;
  assign out_min_key     = out_min_r;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(CAPACITY))
    else $error("entry count beyond capacity");

  a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (XW'(wr_addr) < cnt_x))
    else $error("key store written beyond held entries");

  a_empty_extract: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_req_type == bhq_pkg::REQ_EXTRACT && cnt_r == '0)
    |=> (state_r == S_FIN && status_r == bhq_pkg::ST_EMPTY && cnt_r == '0))
    else $error("extract on empty heap mishandled");
`endif

endmodule

>>> dv/testbench.sv
// Self-checking testbench for binary_min_heap_queue: random and directed requests with checks
// against an in-bench heap model. Depends on bhq_pkg and the binary_min_heap_queue RTL.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CAPACITY = 64;
  localparam int IDLE_LIMIT = 4000;
  localparam int RANDOM_REQS = 1600;
  localparam logic [bhq_pkg::REQ_W-1:0] REQ_UNUSED = 2'd3;

  typedef struct {
    logic [bhq_pkg::REQ_W-1:0] req;
    bhq_pkg::key_t             key;
    logic [bhq_pkg::POS_W-1:0] pos;
    bit                        hold;
  } heap_req_t;

  typedef struct {
    bhq_pkg::key_t                key_out;
    logic [bhq_pkg::STATUS_W-1:0] status;
    logic [bhq_pkg::COUNT_W-1:0]  count;
    bhq_pkg::key_t                min_key;
  } heap_result_t;

  logic                         clk = 1'b0;
  logic                         rst_n = 1'b0;
  logic                         in_valid = 1'b0;
  logic                         in_ready;
  logic [bhq_pkg::REQ_W-1:0]    in_req_type = '0;
  bhq_pkg::key_t                in_new_key = '0;
  logic [bhq_pkg::POS_W-1:0]    in_position = '0;
  logic                         out_valid;
  logic                         out_ready = 1'b0;
  bhq_pkg::key_t                out_key_out;
  logic [bhq_pkg::STATUS_W-1:0] out_status;
  logic [bhq_pkg::COUNT_W-1:0]  out_entry_count;
  bhq_pkg::key_t                out_min_key;

  heap_req_t     request_q[$];
  heap_result_t  pending_results[$];
  bhq_pkg::key_t shadow_keys[CAPACITY];
  int            shadow_count = 0;
  int            mismatches = 0;
  int            total_reqs = 0;
  int            accepted_reqs = 0;
  int unsigned   send_gap = 0;
  int unsigned   recv_gap = 0;
  int unsigned   tx_cycles = 0;
  int unsigned   rx_cycles = 0;
  int            idle_cycles = 0;

  binary_min_heap_queue #(.CAPACITY(CAPACITY)) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_req_type(in_req_type),
    .in_new_key(in_new_key),
    .in_position(in_position),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_key_out(out_key_out),
    .out_status(out_status),
    .out_entry_count(out_entry_count),
    .out_min_key(out_min_key)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int unsigned pick_gap(bit calm);
    int unsigned roll;
    if (calm) return 0;
    roll = $urandom_range(99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  function automatic void heap_raise(int slot);
    int            up;
    bhq_pkg::key_t tmp;
    while (slot > 0) begin
      up = (slot - 1) / 2;
      if (shadow_keys[up] <= shadow_keys[slot]) break;
      tmp = shadow_keys[up];
      shadow_keys[up] = shadow_keys[slot];
      shadow_keys[slot] = tmp;
      slot = up;
    end
  endfunction

  function automatic heap_result_t heap_apply(logic [bhq_pkg::REQ_W-1:0] req,
                                              bhq_pkg::key_t key,
                                              logic [bhq_pkg::POS_W-1:0] pos);
    heap_result_t  r;
    int            slot, lc, rc, pick;
    bhq_pkg::key_t tmp;
    r.key_out = '0;
    r.status  = bhq_pkg::ST_OK;
    case (req)
      bhq_pkg::REQ_INSERT: begin
        if (shadow_count >= CAPACITY) begin
          r.status = bhq_pkg::ST_FULL;
        end else begin
          shadow_keys[shadow_count] = key;
          shadow_count++;
          heap_raise(shadow_count - 1);
        end
      end
      bhq_pkg::REQ_EXTRACT: begin
        if (shadow_count == 0) begin
          r.status  = bhq_pkg::ST_EMPTY;
          r.key_out = bhq_pkg::INT_MAX;
        end else begin
          r.key_out = shadow_keys[0];
          shadow_count--;
          if (shadow_count > 0) begin
            shadow_keys[0] = shadow_keys[shadow_count];
            slot = 0;
            while (slot < shadow_count) begin
              lc = 2 * slot + 1;
              rc = 2 * slot + 2;
              pick = slot;
              if (lc < shadow_count && shadow_keys[lc] < shadow_keys[pick]) pick = lc;
              if (rc < shadow_count && shadow_keys[rc] < shadow_keys[pick]) pick = rc;
              if (pick == slot) break;
              tmp = shadow_keys[pick];
              shadow_keys[pick] = shadow_keys[slot];
              shadow_keys[slot] = tmp;
              slot = pick;
            end
          end
        end
      end
      bhq_pkg::REQ_DECREASE: begin
        if (int'(pos) >= shadow_count) begin
          r.status = bhq_pkg::ST_BADPOS;
        end else if (key > shadow_keys[pos]) begin
          r.status = bhq_pkg::ST_GREATER;
        end else begin
          shadow_keys[pos] = key;
          heap_raise(int'(pos));
        end
      end
      default: ;
    endcase
    r.count   = shadow_count[bhq_pkg::COUNT_W-1:0];
    r.min_key = (shadow_count > 0) ? shadow_keys[0] : bhq_pkg::INT_MAX;
    return r;
  endfunction

  task automatic flag_error(string what);
    $display("%0t mismatch: %s", $realtime, what);
    mismatches++;
  endtask

  task automatic queue_req(logic [bhq_pkg::REQ_W-1:0] req, bhq_pkg::key_t key,
                           logic [bhq_pkg::POS_W-1:0] pos, bit hold);
    heap_req_t item;
    item.req  = req;
    item.key  = key;
    item.pos  = pos;
    item.hold = hold;
    request_q.push_back(item);
    total_reqs++;
  endtask

  function automatic bhq_pkg::key_t draw_key(int mode);
    int unsigned roll;
    roll = $urandom_range(9);
    case (mode)
      0: return bhq_pkg::key_t'($urandom_range(16)) - 8;
      1: return bhq_pkg::key_t'($urandom);
      default: begin
        if (roll < 2) return bhq_pkg::key_t'(32'h8000_0000);
        if (roll < 4) return bhq_pkg::INT_MAX;
        if (roll < 6)
          return bhq_pkg::key_t'(32'h8000_0000) + bhq_pkg::key_t'($urandom_range(3));
        if (roll < 8) return bhq_pkg::INT_MAX - bhq_pkg::key_t'($urandom_range(3));
        return bhq_pkg::key_t'($urandom);
      end
    endcase
  endfunction

  // driver
  always @(posedge clk) begin
    heap_req_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      tx_cycles++;
      if (in_valid && in_ready) begin
        pending_results.push_back(heap_apply(in_req_type, in_new_key, in_position));
        accepted_reqs++;
      end
      if (!in_valid || in_ready) begin
        if (send_gap != 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (request_q.size() != 0 &&
                     !(request_q[0].hold && pending_results.size() != 0)) begin
          nxt = request_q.pop_front();
          in_valid    <= 1'b1;
          in_req_type <= nxt.req;
          in_new_key  <= nxt.key;
          in_position <= nxt.pos;
          send_gap = pick_gap(tx_cycles[8:6] == 3'd0);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    heap_result_t want;
    bit took;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      rx_cycles++;
      took = out_valid && out_ready;
      if (took) begin
        if (pending_results.size() == 0) begin
          flag_error($sformatf("unexpected result key_out=%0d status=%0d count=%0d min=%0d",
                               out_key_out, out_status, out_entry_count, out_min_key));
        end else begin
          want = pending_results.pop_front();
          if (out_key_out !== want.key_out)
            flag_error($sformatf("key_out %0d, want %0d", out_key_out, want.key_out));
          if (out_status !== want.status)
            flag_error($sformatf("status %0d, want %0d", out_status, want.status));
          if (out_entry_count !== want.count)
            flag_error($sformatf("entry_count %0d, want %0d", out_entry_count, want.count));
          if (out_min_key !== want.min_key)
            flag_error($sformatf("min_key %0d, want %0d", out_min_key, want.min_key));
        end
      end
      if (recv_gap != 0) recv_gap--;
      else if (took || $urandom_range(15) == 0) recv_gap = pick_gap(rx_cycles[9:7] == 3'd5);
      out_ready <= (recv_gap == 0);
    end
  end

  // watchdog: cycles with no handshake on either side
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("[binary_min_heap_queue] ERROR");
      $finish;
    end
  end

  initial begin
    int                        fill, made, phase, len, mode, j;
    int unsigned               roll;
    logic [bhq_pkg::REQ_W-1:0] req;
    logic [bhq_pkg::POS_W-1:0] pos;
    bit                        hold;

    // directed: empty cases, extremes, ties, bad positions, unused code
    queue_req(bhq_pkg::REQ_EXTRACT, '0, '0, 1'b0);
    queue_req(bhq_pkg::REQ_DECREASE, -5, 6'd0, 1'b0);
    queue_req(REQ_UNUSED, bhq_pkg::key_t'(32'hFFFF_FFFF), 6'd63, 1'b0);
    queue_req(bhq_pkg::REQ_INSERT, 0, 6'd0, 1'b0);
    queue_req(bhq_pkg::REQ_INSERT, bhq_pkg::INT_MAX, 6'd0, 1'b0);
    queue_req(bhq_pkg::REQ_INSERT, bhq_pkg::key_t'(32'h8000_0000), 6'd0, 1'b0);
    queue_req(bhq_pkg::REQ_INSERT, -1, 6'd0, 1'b0);
    queue_req(bhq_pkg::REQ_INSERT, 1, 6'd0, 1'b0);
    queue_req(bhq_pkg::REQ_INSERT, 5, 6'd0, 1'b0);
    queue_req(bhq_pkg::REQ_INSERT, 5, 6'd0, 1'b0);
    queue_req(bhq_pkg::REQ_DECREASE, bhq_pkg::INT_MAX, 6'd6, 1'b0);
    queue_req(bhq_pkg::REQ_DECREASE, 0, 6'd63, 1'b0);
    queue_req(bhq_pkg::REQ_DECREASE, 0, 6'd7, 1'b0);
    queue_req(bhq_pkg::REQ_DECREASE, bhq_pkg::key_t'(32'h8000_0000), 6'd3, 1'b0);
    queue_req(bhq_pkg::REQ_DECREASE, bhq_pkg::key_t'(32'h8000_0000), 6'd0, 1'b0);
    queue_req(bhq_pkg::REQ_DECREASE, 4, 6'd5, 1'b0);
    queue_req(REQ_UNUSED, 0, 6'd0, 1'b1);
    for (j = 0; j < 8; j++)
      queue_req(bhq_pkg::REQ_EXTRACT, bhq_pkg::key_t'($urandom), 6'($urandom), 1'b0);

    // random phases: fill towards full, drain towards empty, or mixed traffic
    fill = 0;
    made = 0;
    while (made < RANDOM_REQS) begin
      phase = $urandom_range(2);
      len   = $urandom_range(150, 20);
      mode  = $urandom_range(2);
      hold  = (made == 0) || ($urandom_range(3) == 0);
      for (j = 0; j < len; j++) begin
        roll = $urandom_range(99);
        case (phase)
          0: req = (roll < 78) ? bhq_pkg::REQ_INSERT : (roll < 90) ? bhq_pkg::REQ_DECREASE :
                   (roll < 98) ? bhq_pkg::REQ_EXTRACT : REQ_UNUSED;
          1: req = (roll < 78) ? bhq_pkg::REQ_EXTRACT : (roll < 88) ? bhq_pkg::REQ_DECREASE :
                   (roll < 98) ? bhq_pkg::REQ_INSERT : REQ_UNUSED;
          default: req = (roll < 35) ? bhq_pkg::REQ_INSERT :
                         (roll < 65) ? bhq_pkg::REQ_EXTRACT :
                         (roll < 96) ? bhq_pkg::REQ_DECREASE : REQ_UNUSED;
        endcase
        if (req == bhq_pkg::REQ_DECREASE && fill != 0 && $urandom_range(99) < 85)
          pos = 6'($urandom_range(fill - 1));
        else
          pos = 6'($urandom);
        queue_req(req, draw_key(mode), pos, hold && (j == 0));
        if (req == bhq_pkg::REQ_INSERT && fill < CAPACITY) fill++;
        if (req == bhq_pkg::REQ_EXTRACT && fill > 0) fill--;
        if (req != REQ_UNUSED) made++;
      end
    end

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    while (accepted_reqs < total_reqs) @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    if (mismatches == 0) begin
      $display("[binary_min_heap_queue] OK");
    end else begin
      $display("[binary_min_heap_queue] ERROR");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/bhq_pkg.sv
rtl/bhq_cmp.sv
rtl/binary_min_heap_queue.sv
dv/testbench.sv
